### rtl/twwm_pkg.sv
// Shared constants, codes and controller/datapath link types for the window mean block.
`default_nettype none

package twwm_pkg;

  // Default widths of the timestamp and of the sample value.
  localparam int unsigned DEF_TIME_BITS  = 48;
  localparam int unsigned DEF_VALUE_BITS = 16;

  // Width of the weighted sum and of the divider dividend.
  localparam int unsigned SUM_W = 64;
  // Width that holds any exact product with room to spare for the overflow test.
  localparam int unsigned EXT_W = 128;
  // Width of the configuration register index.
  localparam int unsigned CFG_IDX_W = 2;
  // Bits of the write data that hold the default mean.
  localparam int unsigned DFLT_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_START = 2'd0,
    CFG_WINDOW_END   = 2'd1,
    CFG_DEFAULT_MEAN = 2'd2
  } cfg_idx_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cap;        // capture the input transaction
    logic chk;        // window test, duration and magnitude
    logic mul;        // partial products
    logic prod;       // combine partial products
    logic acc;        // accumulate into the pass state
    logic div_init;   // load divider operands
    logic div_step;   // one restoring divide step
    logic load_out;   // load result register and clear the pass
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
    logic tt_zero;
  } sts_t;

endpackage

`default_nettype wire

### rtl/twwm_if.sv
// Valid/ready channel interfaces for the sample input and the result output.
`default_nettype none

interface twwm_in_if #(
  parameter int unsigned TIME_BITS  = twwm_pkg::DEF_TIME_BITS,
  parameter int unsigned VALUE_BITS = twwm_pkg::DEF_VALUE_BITS
);
  logic                         valid;
  logic                         ready;
  logic        [TIME_BITS-1:0]  sample_time;
  logic signed [VALUE_BITS-1:0] sample_value;
  logic                         sample_good;
  logic                         last_sample;

  modport source (output valid, sample_time, sample_value, sample_good, last_sample,
                  input ready);
  modport sink (input valid, sample_time, sample_value, sample_good, last_sample,
                output ready);
endinterface

interface twwm_out_if #(
  parameter int unsigned VALUE_BITS = twwm_pkg::DEF_VALUE_BITS
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] mean_value;
  logic                         used_default;
  logic                         sum_overflow;

  modport source (output valid, mean_value, used_default, sum_overflow, input ready);
  modport sink (input valid, mean_value, used_default, sum_overflow, output ready);
endinterface

`default_nettype wire

### rtl/time_weighted_window_mean.sv
// Top level of the time-weighted window mean: controller, datapath and channel hookup.
// A sample transaction that does not end a history runs from acceptance through
// window test, two-part multiply, product merge and accumulate to the next acceptance.
// The last sample adds a restoring divide, one quotient bit per cycle, plus setup
// and result load; the divide is skipped and the default mean is loaded if no time
// was accumulated. Reset is asynchronous and active low; no clearing pass is needed.
`default_nettype none

module time_weighted_window_mean #(
  parameter int unsigned TIME_BITS  = twwm_pkg::DEF_TIME_BITS,
  parameter int unsigned VALUE_BITS = twwm_pkg::DEF_VALUE_BITS
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [twwm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [TIME_BITS-1:0]           cfg_data_i,
  twwm_in_if.sink                             in_if,
  twwm_out_if.source                          out_if
);

  twwm_pkg::cmd_t cmd;
  twwm_pkg::sts_t sts;

  logic [VALUE_BITS-1:0] mean_value;

  // The controller only accepts a transaction when the datapath is free, and it
  // holds a finished result in the output register so the next sample can be
  // taken while the consumer stalls.
  twwm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath keeps the window registers, the running pass state and the
  // arithmetic units. A write to the window start also restarts the pass.
  twwm_dp #(
    .TIME_BITS  (TIME_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .sample_time_i  (in_if.sample_time),
    .sample_value_i (in_if.sample_value),
    .sample_good_i  (in_if.sample_good),
    .last_sample_i  (in_if.last_sample),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .mean_value_o   (mean_value),
    .used_default_o (out_if.used_default),
    .sum_overflow_o (out_if.sum_overflow)
  );

  // The mean is carried as a signed value on the output channel.
  assign out_if.mean_value = $signed(mean_value);

endmodule

`default_nettype wire

### rtl/twwm_ctrl.sv
// Controller state machine that sequences the datapath for each transaction.
`default_nettype none

module twwm_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire twwm_pkg::sts_t sts_i,
  output twwm_pkg::cmd_t     cmd_o
);

  localparam int unsigned CNT_W = $clog2(twwm_pkg::SUM_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK,
    ST_MUL,
    ST_PROD,
    ST_ACC,
    ST_DPREP,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic             out_valid_q;
  logic             out_free;

  // The result register can take a new result when empty or being drained.
  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.cap      = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.chk      = (state_q == ST_CHK);
    cmd_o.mul      = (state_q == ST_MUL);
    cmd_o.prod     = (state_q == ST_PROD);
    cmd_o.acc      = (state_q == ST_ACC);
    cmd_o.div_init = (state_q == ST_DPREP);
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.load_out = (state_q == ST_FIN) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // A new result fills the output register; otherwise a drained one empties it.
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_CHK;
          end
        end
        ST_CHK:  state_q <= ST_MUL;
        ST_MUL:  state_q <= ST_PROD;
        ST_PROD: state_q <= ST_ACC;
        ST_ACC: begin
          state_q <= sts_i.last ? ST_DPREP : ST_IDLE;
        end
        ST_DPREP: begin
          if (sts_i.tt_zero) begin
            state_q <= ST_FIN;
          end else begin
            state_q <= ST_DIV;
            cnt_q   <= CNT_W'(twwm_pkg::SUM_W - 1);
          end
        end
        ST_DIV: begin
          if (cnt_q == '0) begin
            state_q <= ST_FIN;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/twwm_dp.sv
// Datapath: configuration, pass state, split multiplier, accumulator and divider.
`default_nettype none

module twwm_dp #(
  parameter int unsigned TIME_BITS  = twwm_pkg::DEF_TIME_BITS,
  parameter int unsigned VALUE_BITS = twwm_pkg::DEF_VALUE_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [twwm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [TIME_BITS-1:0]          cfg_data_i,
  input  wire logic [TIME_BITS-1:0]          sample_time_i,
  input  wire logic [VALUE_BITS-1:0]         sample_value_i,
  input  wire logic                          sample_good_i,
  input  wire logic                          last_sample_i,
  input  wire twwm_pkg::cmd_t                cmd_i,
  output twwm_pkg::sts_t                     sts_o,
  output logic [VALUE_BITS-1:0]              mean_value_o,
  output logic                               used_default_o,
  output logic                               sum_overflow_o
);

  localparam int unsigned SUM_W = twwm_pkg::SUM_W;
  localparam int unsigned EXT_W = twwm_pkg::EXT_W;
  localparam int unsigned LO_W  = (TIME_BITS + 1) / 2;
  localparam int unsigned HI_W  = TIME_BITS - LO_W;
  localparam int unsigned PW    = TIME_BITS + VALUE_BITS;
  localparam logic [SUM_W-1:0] BIT_TOP = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [SUM_W-1:0] Q_NEG   = {{(SUM_W-1){1'b0}}, 1'b1} << (VALUE_BITS - 1);
  localparam logic [SUM_W-1:0] Q_POS   = Q_NEG - 1'b1;

  // Configuration and pass state.
  logic [TIME_BITS-1:0]  ws_q, we_q;
  logic [VALUE_BITS-1:0] dm_q;
  logic [SUM_W-1:0]      sum_q, sum_d;
  logic [TIME_BITS-1:0]  tt_q, tt_d;
  logic [TIME_BITS-1:0]  ps_q, ps_d;
  logic                  ovf_q, ovf_d;

  // Per-transaction working registers.
  logic [TIME_BITS-1:0]        t_q;
  logic [VALUE_BITS-1:0]       v_q;
  logic                        good_q, last_q;
  logic                        hit_q, use_q, neg_q;
  logic [TIME_BITS-1:0]        dur_q;
  logic [VALUE_BITS-1:0]       mag_q;
  logic [LO_W+VALUE_BITS-1:0]  lo_q;
  logic [HI_W+VALUE_BITS-1:0]  hi_q;
  logic [SUM_W-1:0]            prod_q;
  logic                        big_q;

  // Divider.
  logic                  sneg_q;
  logic [SUM_W-1:0]      quo_q;
  logic [TIME_BITS-1:0]  rem_q;
  logic [TIME_BITS:0]    rem_sh;
  logic [TIME_BITS:0]    rem_sub;

  // Result register.
  logic [VALUE_BITS-1:0] mean_q;
  logic                  used_q, oflow_q;

  logic [PW-1:0]         prod_full;
  logic [EXT_W-1:0]      prod_ext;
  logic [SUM_W-1:0]      sum_add, sum_sub;
  logic [SUM_W-1:0]      q_sat;
  logic [VALUE_BITS-1:0] mean_d;
  logic                  tt_zero;

  assign tt_zero       = (tt_q == '0);
  assign sts_o.last    = last_q;
  assign sts_o.tt_zero = tt_zero;

  assign prod_full = (PW'(hi_q) << LO_W) + PW'(lo_q);
  assign prod_ext  = EXT_W'(prod_full);

  assign sum_add = sum_q + prod_q;
  assign sum_sub = sum_q - prod_q;

  // Accumulation with signed 64-bit overflow tracking.
  always_comb begin
    sum_d = sum_q;
    tt_d  = tt_q;
    ps_d  = ps_q;
    ovf_d = ovf_q;
    if (use_q) begin
      tt_d = tt_q + dur_q;
      if (!neg_q) begin
        sum_d = sum_add;
        if (big_q || prod_q[SUM_W-1] || (!sum_q[SUM_W-1] && sum_add[SUM_W-1])) begin
          ovf_d = 1'b1;
        end
      end else begin
        sum_d = sum_sub;
        if (big_q || (prod_q > BIT_TOP) || (sum_q[SUM_W-1] && !sum_sub[SUM_W-1])) begin
          ovf_d = 1'b1;
        end
      end
    end
    if (hit_q) begin
      ps_d = t_q;
    end
  end

  assign rem_sh  = {rem_q, quo_q[SUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, tt_q};

  // Quotient saturation to the signed value range, then the sign is applied.
  always_comb begin
    if (sneg_q) begin
      q_sat  = (quo_q > Q_NEG) ? Q_NEG : quo_q;
      mean_d = -q_sat[VALUE_BITS-1:0];
    end else begin
      q_sat  = (quo_q > Q_POS) ? Q_POS : quo_q;
      mean_d = q_sat[VALUE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q  <= '0;
      we_q  <= '1;
      dm_q  <= '0;
      sum_q <= '0;
      tt_q  <= '0;
      ps_q  <= '0;
      ovf_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (twwm_pkg::cfg_idx_e'(cfg_idx_i))
          twwm_pkg::CFG_WINDOW_START: begin
            ws_q  <= cfg_data_i;
            sum_q <= '0;
            tt_q  <= '0;
            ps_q  <= cfg_data_i;
            ovf_q <= 1'b0;
          end
          twwm_pkg::CFG_WINDOW_END:   we_q <= cfg_data_i;
          twwm_pkg::CFG_DEFAULT_MEAN: dm_q <= VALUE_BITS'(cfg_data_i[twwm_pkg::DFLT_W-1:0]);
          default: ;
        endcase
      end else if (cmd_i.acc) begin
        sum_q <= sum_d;
        tt_q  <= tt_d;
        ps_q  <= ps_d;
        ovf_q <= ovf_d;
      end else if (cmd_i.load_out) begin
        sum_q <= '0;
        tt_q  <= '0;
        ps_q  <= ws_q;
        ovf_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      t_q    <= sample_time_i;
      v_q    <= sample_value_i;
      good_q <= sample_good_i;
      last_q <= last_sample_i;
    end
    if (cmd_i.chk) begin
      hit_q <= (t_q >= ps_q) && (t_q < we_q);
      use_q <= (t_q >= ps_q) && (t_q < we_q) && good_q;
      dur_q <= t_q - ps_q;
      neg_q <= v_q[VALUE_BITS-1];
      // The most negative value negates to itself, which reads as its magnitude.
      mag_q <= v_q[VALUE_BITS-1] ? -v_q : v_q;
    end
    if (cmd_i.mul) begin
      lo_q <= dur_q[LO_W-1:0] * mag_q;
      hi_q <= dur_q[TIME_BITS-1:LO_W] * mag_q;
    end
    if (cmd_i.prod) begin
      prod_q <= prod_ext[SUM_W-1:0];
      big_q  <= |prod_ext[EXT_W-1:SUM_W];
    end
    if (cmd_i.div_init) begin
      sneg_q <= sum_q[SUM_W-1];
      quo_q  <= sum_q[SUM_W-1] ? -sum_q : sum_q;
      rem_q  <= '0;
    end else if (cmd_i.div_step) begin
      if (!rem_sub[TIME_BITS]) begin
        rem_q <= rem_sub[TIME_BITS-1:0];
        quo_q <= {quo_q[SUM_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[TIME_BITS-1:0];
        quo_q <= {quo_q[SUM_W-2:0], 1'b0};
      end
    end
    if (cmd_i.load_out) begin
      mean_q  <= tt_zero ? dm_q : mean_d;
      used_q  <= tt_zero;
      oflow_q <= ovf_q;
    end
  end

  assign mean_value_o   = mean_q;
  assign used_default_o = used_q;
  assign sum_overflow_o = oflow_q;

endmodule

`default_nettype wire
